// File: src/dual_global_pooling_defines.svh
// Assertion macros shared by the dual_global_pooling RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef DUAL_GLOBAL_POOLING_DEFINES_SVH
`define DUAL_GLOBAL_POOLING_DEFINES_SVH

`ifndef SYNTHESIS

`define DGP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dgp assertion failed");

`define DGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dgp assertion failed");

`else

`define DGP_ASSERT(lbl, cond)

`define DGP_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// File: src/dgp_pkg.sv
// Shared constants and types for the dual global pooling block.
// No dependencies.
`timescale 1ns / 1ps

package dgp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int MAX_LENGTH   = 1024;
  localparam int MAX_CHANNELS = 256;
  localparam int LEN_W        = $clog2(MAX_LENGTH) + 1;
  localparam int CNT_W        = $clog2(MAX_LENGTH);
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CHN_W        = CH_W + 1;
  localparam int SUM_W        = SAMPLE_W + $clog2(MAX_LENGTH);
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = LEN_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH) + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] max;
    logic [CH_W-1:0]            chan;
    logic [LEN_W-1:0]           len;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/dgp_front.sv
// Front end: configuration registers, sum/max accumulation, group close.
// Depends on dgp_pkg; pushes closed groups into dgp_queue.
`timescale 1ns / 1ps

module dgp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dgp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [dgp_pkg::SAMPLE_W-1:0] in_sample,
  input  dgp_pkg::q_stat_t                 q_stat,
  output logic                             push,
  output dgp_pkg::grp_t                    push_data
);

  logic [dgp_pkg::LEN_W-1:0]           len_r;
  logic [dgp_pkg::CHN_W-1:0]           chn_r;
  logic signed [dgp_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [dgp_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic [dgp_pkg::CNT_W-1:0]           cnt_r;
  logic [dgp_pkg::CH_W-1:0]            ch_r, ch_nxt;
  logic [dgp_pkg::LEN_W-1:0]           eff_len;
  logic [dgp_pkg::CHN_W-1:0]           eff_chn, ch_inc;
  logic                                acc, last;

  always_comb begin
    if (len_r == '0) begin
      eff_len = dgp_pkg::LEN_W'(1);
    end else if (len_r > dgp_pkg::LEN_W'(dgp_pkg::MAX_LENGTH)) begin
      eff_len = dgp_pkg::LEN_W'(dgp_pkg::MAX_LENGTH);
    end else begin
      eff_len = len_r;
    end
    if (chn_r == '0) begin
      eff_chn = dgp_pkg::CHN_W'(1);
    end else if (chn_r > dgp_pkg::CHN_W'(dgp_pkg::MAX_CHANNELS)) begin
      eff_chn = dgp_pkg::CHN_W'(dgp_pkg::MAX_CHANNELS);
    end else begin
      eff_chn = chn_r;
    end
  end

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign sum_nxt  = sum_r + {{(dgp_pkg::SUM_W-dgp_pkg::SAMPLE_W){in_sample[dgp_pkg::SAMPLE_W-1]}},
                             in_sample};
  assign max_nxt  = (in_sample > max_r) ? in_sample : max_r;
  assign last     = ({1'b0, cnt_r} + dgp_pkg::LEN_W'(1)) >= eff_len;
  assign ch_inc   = {1'b0, ch_r} + dgp_pkg::CHN_W'(1);
  assign ch_nxt   = (ch_inc >= eff_chn) ? '0 : ch_inc[dgp_pkg::CH_W-1:0];

  assign push           = acc && last;
  assign push_data.sum  = sum_nxt;
  assign push_data.max  = max_nxt;
  assign push_data.chan = ch_r;
  assign push_data.len  = eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= dgp_pkg::LEN_W'(1);
      chn_r <= dgp_pkg::CHN_W'(1);
      sum_r <= '0;
      max_r <= dgp_pkg::MOST_NEG;
      cnt_r <= '0;
      ch_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dgp_pkg::REG_GROUP_LENGTH:  len_r <= cfg_wdata;
          dgp_pkg::REG_CHANNEL_COUNT: chn_r <= cfg_wdata[dgp_pkg::CHN_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        if (last) begin
          sum_r <= '0;
          max_r <= dgp_pkg::MOST_NEG;
          cnt_r <= '0;
          ch_r  <= ch_nxt;
        end else begin
          sum_r <= sum_nxt;
          max_r <= max_nxt;
          cnt_r <= cnt_r + dgp_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule

// File: src/dgp_queue.sv
// Two-entry queue of closed groups between front end and divider.
// Depends on dgp_pkg and dual_global_pooling_defines.svh.
`timescale 1ns / 1ps
`include "dual_global_pooling_defines.svh"

module dgp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dgp_pkg::grp_t    push_data,
  input  logic             pop,
  output dgp_pkg::grp_t    pop_data,
  output dgp_pkg::q_stat_t q_stat
);

  dgp_pkg::grp_t                ent_r [dgp_pkg::QUEUE_DEPTH];
  logic [dgp_pkg::QPTR_W-1:0]   wp_r, rp_r;
  logic [dgp_pkg::QCNT_W-1:0]   cnt_r;

  assign q_stat.full  = cnt_r == dgp_pkg::QCNT_W'(dgp_pkg::QUEUE_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign pop_data     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + dgp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + dgp_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + dgp_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - dgp_pkg::QCNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  `DGP_ASSERT(a_no_overflow, !(push && q_stat.full))
  `DGP_ASSERT(a_no_underflow, !(pop && q_stat.empty))

endmodule

// File: src/dgp_div.sv
// Back end: shift-subtract divider for the mean and the output register.
// Depends on dgp_pkg and dual_global_pooling_defines.svh.
`timescale 1ns / 1ps
`include "dual_global_pooling_defines.svh"

module dgp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dgp_pkg::q_stat_t                    q_stat,
  input  dgp_pkg::grp_t                       pop_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dgp_pkg::SAMPLE_W-1:0] out_mean,
  output logic signed [dgp_pkg::SAMPLE_W-1:0] out_maximum,
  output logic [dgp_pkg::CH_W-1:0]            out_channel_index
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t                              st_r;
  logic [dgp_pkg::SUM_W-1:0]           dvd_r, dvd_nxt, mag;
  logic [dgp_pkg::LEN_W-1:0]           rem_r, rem_nxt, den_r;
  logic [dgp_pkg::LEN_W:0]             rem_sh;
  logic [dgp_pkg::STEP_W-1:0]          step_r;
  logic                                neg_r, ge, at_end, slot_free, load;
  logic signed [dgp_pkg::SAMPLE_W-1:0] max_r;
  logic [dgp_pkg::CH_W-1:0]            ch_r;
  logic [dgp_pkg::SAMPLE_W-1:0]        quo;

  assign pop       = (st_r == ST_IDLE) && !q_stat.empty;
  assign mag       = pop_data.sum[dgp_pkg::SUM_W-1] ? (~pop_data.sum + dgp_pkg::SUM_W'(1))
                                                    : pop_data.sum;
  assign rem_sh    = {rem_r, dvd_r[dgp_pkg::SUM_W-1]};
  assign ge        = rem_sh >= {1'b0, den_r};
  assign rem_nxt   = ge ? dgp_pkg::LEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[dgp_pkg::LEN_W-1:0];
  assign dvd_nxt   = {dvd_r[dgp_pkg::SUM_W-2:0], ge};
  assign at_end    = step_r == dgp_pkg::STEP_W'(dgp_pkg::SUM_W - 1);
  assign slot_free = !out_valid || out_ready;
  assign load      = (st_r == ST_DIV) && at_end && slot_free;
  assign quo       = dvd_nxt[dgp_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      step_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (pop) begin
            dvd_r  <= mag;
            rem_r  <= '0;
            den_r  <= pop_data.len;
            neg_r  <= pop_data.sum[dgp_pkg::SUM_W-1];
            max_r  <= pop_data.max;
            ch_r   <= pop_data.chan;
            step_r <= '0;
            st_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!at_end) begin
            dvd_r  <= dvd_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r + dgp_pkg::STEP_W'(1);
          end else if (slot_free) begin
            out_mean          <= neg_r ? -quo : quo;
            out_maximum       <= max_r;
            out_channel_index <= ch_r;
            out_valid         <= 1'b1;
            st_r              <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `DGP_ASSERT_IMP(a_den_nonzero, st_r == ST_DIV, den_r != '0)
  `DGP_ASSERT_IMP(a_rem_bound, load, rem_nxt < den_r)

endmodule

// File: src/dual_global_pooling.sv
// Global average and max pooling over a stream of signed Q8.8 samples.
// Front end accepts one sample per cycle while the queue is not full, and closes
// a group after group_length samples; closed groups wait in a two-entry queue;
// the back end divides the group sum by the length with a 26-step shift-subtract
// divider and takes the next group from the queue only when it is idle, so
// shorter groups are paced by the divider. Results: mean (truncated toward zero),
// maximum, channel index.
// Depends on dgp_pkg, dgp_front, dgp_queue, dgp_div.
`timescale 1ns / 1ps

module dual_global_pooling (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dgp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dgp_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dgp_pkg::SAMPLE_W-1:0] out_mean,
  output logic signed [dgp_pkg::SAMPLE_W-1:0] out_maximum,
  output logic [dgp_pkg::CH_W-1:0]            out_channel_index
);

  dgp_pkg::q_stat_t q_stat;
  dgp_pkg::grp_t    push_data, pop_data;
  logic             push, pop;

  dgp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  dgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  dgp_div u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean          (out_mean),
    .out_maximum       (out_maximum),
    .out_channel_index (out_channel_index)
  );

endmodule

// File: dv/dgp_checker.sv
// Scoreboard for dual_global_pooling: mirrors the pooling arithmetic on every accepted
// sample and register write, then checks each accepted result in order.
// Depends on dgp_pkg.
`timescale 1ns / 1ps

module dgp_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dgp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [dgp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [dgp_pkg::SAMPLE_W-1:0] out_mean,
  input  logic signed [dgp_pkg::SAMPLE_W-1:0] out_maximum,
  input  logic [dgp_pkg::CH_W-1:0]            out_channel_index,
  output int                                  fail_count,
  output int                                  pending_results
);
  import dgp_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [CH_W-1:0]            chan;
  } pool_result_t;

  pool_result_t               pool_q[$];
  logic [CFG_DATA_W-1:0]      length_reg;
  logic [8:0]                 count_reg;
  logic signed [SUM_W-1:0]    group_sum;
  logic signed [SAMPLE_W-1:0] group_max;
  int unsigned                group_fill;
  logic [CH_W-1:0]            chan_ctr;
  int                         errs = 0;

  task automatic clear_group();
    group_sum  = '0;
    group_max  = MOST_NEG;
    group_fill = 0;
  endtask

  always @(posedge clk) begin : track
    pool_result_t               want;
    logic signed [SAMPLE_W-1:0] s;
    int unsigned                len_eff;
    int unsigned                chan_eff;
    int unsigned                nxt;
    longint                     quot;
    if (!rst_n) begin
      length_reg = CFG_DATA_W'(1);
      count_reg  = 9'd1;
      chan_ctr   = '0;
      clear_group();
      pool_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pool_q.size() == 0) begin
          errs++;
          $error("result with none expected: mean %0d maximum %0d channel_index %0d",
                 out_mean, out_maximum, out_channel_index);
        end else begin
          want = pool_q.pop_front();
          if (out_mean !== want.mean) begin
            errs++;
            $error("mean: expected %0d, got %0d", want.mean, out_mean);
          end
          if (out_maximum !== want.maximum) begin
            errs++;
            $error("maximum: expected %0d, got %0d", want.maximum, out_maximum);
          end
          if (out_channel_index !== want.chan) begin
            errs++;
            $error("channel_index: expected %0d, got %0d", want.chan, out_channel_index);
          end
        end
      end

      if (in_valid && in_ready) begin
        s = in_sample;
        group_sum = group_sum + s;
        if (s > group_max)
          group_max = s;
        len_eff = (length_reg == '0) ? 1 :
                  (length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg;
        if (group_fill + 1 < len_eff) begin
          group_fill++;
        end else begin
          quot         = longint'(group_sum) / longint'(len_eff);
          want.mean    = quot[SAMPLE_W-1:0];
          want.maximum = group_max;
          want.chan    = chan_ctr;
          pool_q.push_back(want);
          chan_eff = (count_reg == '0) ? 1 :
                     (count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg;
          nxt = chan_ctr + 1;
          if (nxt >= chan_eff)
            nxt = 0;
          chan_ctr = nxt[CH_W-1:0];
          clear_group();
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_GROUP_LENGTH:  length_reg = cfg_wdata;
          REG_CHANNEL_COUNT: count_reg  = cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
    fail_count      <= errs;
    pending_results <= pool_q.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the dual_global_pooling bench: clock, reset, register writes, sample stimulus
// with bursts and gaps, a stalling result sink and the final verdict.
// Depends on dgp_pkg, dgp_checker and the dual_global_pooling RTL.
`timescale 1ns / 1ps

module testbench;
  import dgp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 950;
  localparam int LONG_ITEMS    = 200;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic signed [SAMPLE_W-1:0] out_mean;
  logic signed [SAMPLE_W-1:0] out_maximum;
  logic [CH_W-1:0]       out_channel_index;
  int                    fail_count;
  int                    pending_results;

  int burst_left = 0;
  bit steady     = 1'b0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int rx_cycle   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_global_pooling dut (.*);

  dgp_checker pool_check (.*);

  // result sink: rotating stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 1500) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(3) != 0);
        2:       out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ((rx_cycle % 7) < 2);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait until every expected result is out, then let the divider settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
    input logic signed [SAMPLE_W-1:0] prev
  );
    case ($urandom_range(9))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return MOST_NEG;
      2:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
      3:       return prev;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int unsigned len_cfg, input int unsigned chan_cfg,
                           input int unsigned n_items, input bit hold);
    logic signed [SAMPLE_W-1:0] v;
    drain();
    write_reg(REG_GROUP_LENGTH, len_cfg);
    write_reg(REG_CHANNEL_COUNT, chan_cfg);
    steady     = hold || ($urandom_range(3) == 0);
    burst_left = $urandom_range(0, 24);
    if (hold)
      hold_req <= hold_req + 1;
    v = '0;
    repeat (n_items) begin
      v = pick_sample(v);
      send_sample(v);
    end
  endtask

  initial begin : stimulus
    int unsigned len_cfg;
    int unsigned chan_cfg;
    int unsigned len_eff;
    int unsigned n_items;
    int unsigned rand_sent;
    bit          big_done;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one sample per group, one channel
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    send_sample(MOST_NEG);
    send_sample('0);
    send_sample(-16'sd1);
    drain();

    // zero length and zero count act as one; spare indices are ignored
    write_reg(REG_GROUP_LENGTH, 0);
    write_reg(REG_CHANNEL_COUNT, 0);
    write_reg(REG_SPARE_LO, 5);
    write_reg(REG_SPARE_HI, 7);
    send_sample(16'sh1234);
    send_sample(-16'sh0101);
    drain();

    // pairs: all most negative, all most positive, negative mean truncation, tie
    write_reg(REG_GROUP_LENGTH, 2);
    write_reg(REG_CHANNEL_COUNT, 3);
    send_sample(MOST_NEG);
    send_sample(MOST_NEG);
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    send_sample(-16'sd3);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sd5);
    drain();

    // length shortened mid-group
    write_reg(REG_GROUP_LENGTH, 4);
    send_sample(16'sd100);
    send_sample(-16'sd300);
    drain();
    write_reg(REG_GROUP_LENGTH, 2);
    send_sample(16'sd7);
    drain();

    // channel count shortened mid-batch
    write_reg(REG_GROUP_LENGTH, 1);
    write_reg(REG_CHANNEL_COUNT, 5);
    send_sample(16'sd11);
    send_sample(-16'sd12);
    send_sample(16'sd13);
    drain();
    write_reg(REG_CHANNEL_COUNT, 2);
    send_sample(16'sd14);
    send_sample(-16'sd15);

    // sink holds off while samples keep coming; index wraps at the channel limit
    run_phase(1, 511, 300, 1'b1);
    rand_sent = 300;
    big_done  = 1'b0;
    while (rand_sent < RANDOM_ITEMS) begin
      if (!big_done && rand_sent >= 500) begin
        big_done = 1'b1;
        // oversized length leaves a long open group for the next, shorter length
        run_phase(2047, $urandom_range(1, 4), LONG_ITEMS, 1'b0);
        rand_sent += LONG_ITEMS;
      end else begin
        case ($urandom_range(19))
          0, 1:    len_cfg = 0;
          2, 3:    len_cfg = $urandom_range(41, 96);
          4, 5, 6,
          7, 8:    len_cfg = $urandom_range(9, 40);
          default: len_cfg = $urandom_range(1, 8);
        endcase
        case ($urandom_range(9))
          0:       chan_cfg = 1;
          1:       chan_cfg = MAX_CHANNELS;
          2:       chan_cfg = 0;
          3:       chan_cfg = 511;
          default: chan_cfg = $urandom_range(2, 12);
        endcase
        len_eff = (len_cfg == 0) ? 1 : len_cfg;
        n_items = len_eff * ($urandom_range(1, 4) + 48 / len_eff);
        // leave a partial group behind now and then
        if ($urandom_range(3) == 0)
          n_items += $urandom_range(1, len_eff);
        run_phase(len_cfg, chan_cfg, n_items, 1'b0);
        rand_sent += n_items;
      end
    end

    drain();
    if (fail_count == 0 && pending_results == 0)
      $display("dual_global_pooling: match");
    else
      $display("dual_global_pooling: mismatch");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("dual_global_pooling: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/dgp_pkg.sv
src/dgp_front.sv
src/dgp_queue.sv
src/dgp_div.sv
src/dual_global_pooling.sv
dv/dgp_checker.sv
dv/testbench.sv
